// File: design/i2cm_pkg.sv
package i2cm_pkg;

  localparam int StepsPerCycle = 4;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_BEGIN = 2'd1;
  localparam logic [1:0] MODE_BYTE  = 2'd2;

  localparam logic [1:0] KIND_WRITE     = 2'd0;
  localparam logic [1:0] KIND_READ      = 2'd1;
  localparam logic [1:0] KIND_REG_WRITE = 2'd2;
  localparam logic [1:0] KIND_REG_READ  = 2'd3;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_BUS_ERR  = 3'd1;
  localparam logic [2:0] STATUS_ADDR_NAK = 3'd2;
  localparam logic [2:0] STATUS_DATA_NAK = 3'd3;
  localparam logic [2:0] STATUS_UNSUPP   = 3'd4;

  localparam logic [1:0] RAW_8  = 2'd0;
  localparam logic [1:0] RAW_16 = 2'd1;

  localparam logic [2:0] CFG_DEV_ADDR = 3'd0;
  localparam logic [2:0] CFG_TEN_BIT  = 3'd1;
  localparam logic [2:0] CFG_RAW      = 3'd2;
  localparam logic [2:0] CFG_HALF     = 3'd3;
  localparam logic [2:0] CFG_STR_EN   = 3'd4;
  localparam logic [2:0] CFG_STR_TO   = 3'd5;

  localparam logic [7:0] ACK_BYTE  = 8'h00;
  localparam logic [7:0] NACK_BYTE = 8'h80;

  typedef enum logic [4:0] {
    P_IDLE, P_ST1, P_ST2, P_ST3, P_RS1, P_RS2, P_RS3, P_RS4,
    P_SP0, P_SP1, P_SP2, P_SP3, P_SP4, P_SP5,
    P_WB0, P_WB1, P_WB2, P_WB3, P_RBD, P_RB1, P_RB2, P_RB3, P_NEXT, P_REQ
  } phase_t;

  typedef enum logic [2:0] {
    S_A1, S_A2, S_AFTER, S_RLO, S_RDONE, S_RA, S_DW, S_DR
  } stage_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  kind;
    logic [15:0] reg_addr;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        scl_level;
    logic        sda_level;
  } in_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       byte_request;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic [9:0]  device_address;
    logic        ten_bit_address;
    logic [1:0]  reg_addr_width;
    logic [15:0] half_period;
    logic        stretch_enable;
    logic [15:0] stretch_timeout;
  } cfg_t;

endpackage

// File: design/i2cm_cfg.sv
module i2cm_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output i2cm_pkg::cfg_t    cfg
);
  import i2cm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address  <= '0;
      cfg.ten_bit_address <= 1'b0;
      cfg.reg_addr_width  <= RAW_8;
      cfg.half_period     <= 16'd5;
      cfg.stretch_enable  <= 1'b0;
      cfg.stretch_timeout <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEV_ADDR: cfg.device_address  <= cfg_data[9:0];
        CFG_TEN_BIT:  cfg.ten_bit_address <= cfg_data[0];
        CFG_RAW:      cfg.reg_addr_width  <= cfg_data[1:0];
        CFG_HALF:     cfg.half_period     <= cfg_data;
        CFG_STR_EN:   cfg.stretch_enable  <= cfg_data[0];
        CFG_STR_TO:   cfg.stretch_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: design/i2c_master_controller.sv
// I2C master, bit level, open drain: a drive of 1 releases the line, 0 pulls it low.
// Input channel (in_valid, in_stall, in_data): each transfer is one item. A tick item
// stands for one microsecond of bus time and carries the sampled SCL and SDA levels.
// A begin item latches a transaction and a byte item supplies a requested write byte.
// Output channel (out_valid, out_stall, out_data): exactly one result per item, with
// the line drives, any received byte and the busy, done and status flags.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// the user must write it only while the block is idle, as the block does not enforce this.
// The bus actions of a tick are run four sequencer steps per cycle. With a nonzero
// half_period they always fit in one pass, so the result is registered on the same edge
// that accepts the item, and one item is taken every cycle unless the output stalls.
// With half_period zero a tick can clock a whole byte, up to 43 steps; the block then
// keeps stepping with in_stall high before the result is registered.
// While the output is stalled with a result waiting, in_stall is high and no item
// is taken; nothing is lost. Reset releases both lines, returns to idle and loads
// the register defaults.
module i2c_master_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2cm_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output i2cm_pkg::out_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import i2cm_pkg::*;

  typedef struct packed {
    phase_t      phase;
    stage_t      stage;
    logic [3:0]  bit_index;
    logic [7:0]  shift_byte;
    logic [15:0] delay_count;
    logic [15:0] stretch_count;
    logic [15:0] bytes_left;
    logic [1:0]  held_kind;
    logic [15:0] held_reg_addr;
    logic [2:0]  held_status;
    logic        scl_d;
    logic        sda_d;
    logic        rx_mode;
    logic        addr_flag;
  } core_t;

  typedef struct packed {
    core_t      s;
    logic [7:0] out_byte;
    logic       out_vld;
    logic       out_done;
    logic       stop;
  } step_t;

  cfg_t  cfg;
  core_t core;
  core_t core_next;
  step_t x;
  step_t work;
  step_t work_next;
  logic  stepping;
  logic  finish;
  logic  accept;

  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  function automatic step_t f_go(step_t a, phase_t nxt, logic wait_en, cfg_t c);
    step_t r;
    r = a;
    r.s.phase = nxt;
    if (wait_en && c.half_period != 16'd0) begin
      r.s.delay_count = c.half_period;
      r.stop = 1'b1;
    end else begin
      r.stop = 1'b0;
    end
    return r;
  endfunction

  function automatic step_t f_send(step_t a, logic [7:0] b, logic is_addr, cfg_t c);
    step_t r;
    r = a;
    r.s.shift_byte = b;
    r.s.bit_index = 4'd0;
    r.s.rx_mode = 1'b0;
    r.s.addr_flag = is_addr;
    return f_go(r, P_WB0, 1'b1, c);
  endfunction

  function automatic step_t f_stretch(step_t a, cfg_t c, logic first, logic scl,
                                      phase_t nxt);
    step_t r;
    r = a;
    if (!c.stretch_enable) return f_go(r, nxt, 1'b1, c);
    if (!first) begin
      r.stop = 1'b1;
      return r;
    end
    if (scl || r.s.stretch_count >= c.stretch_timeout) begin
      r.s.stretch_count = 16'd0;
      return f_go(r, nxt, 1'b1, c);
    end
    r.s.stretch_count = r.s.stretch_count + 16'd1;
    r.stop = 1'b1;
    return r;
  endfunction

  function automatic step_t f_seq(step_t a, cfg_t c);
    step_t      r;
    logic [7:0] hi;
    logic [7:0] lo7;
    logic       dir;
    r   = a;
    hi  = {5'b11110, c.device_address[9:8], 1'b0};
    lo7 = {c.device_address[6:0], 1'b0};
    dir = (r.s.held_kind == KIND_READ) && !c.ten_bit_address;
    r.stop = 1'b0;
    unique case (r.s.stage)
      S_A1: begin
        if (c.ten_bit_address) begin
          r.s.stage = S_A2;
          r = f_send(r, hi, 1'b1, c);
        end else begin
          r.s.stage = S_AFTER;
          r = f_send(r, lo7 | {7'd0, dir}, 1'b1, c);
        end
      end
      S_A2: begin
        r.s.stage = S_AFTER;
        r = f_send(r, c.device_address[7:0], 1'b1, c);
      end
      S_AFTER: begin
        if (r.s.held_kind == KIND_WRITE) begin
          r.s.stage = S_DW;
        end else if (r.s.held_kind == KIND_READ) begin
          if (c.ten_bit_address) begin
            r.s.stage = S_RA;
            r = f_go(r, P_RS1, 1'b1, c);
          end else begin
            r.s.stage = S_DR;
          end
        end else if (c.reg_addr_width == RAW_8) begin
          r.s.stage = S_RDONE;
          r = f_send(r, r.s.held_reg_addr[7:0], 1'b0, c);
        end else if (c.reg_addr_width == RAW_16) begin
          r.s.stage = S_RLO;
          r = f_send(r, r.s.held_reg_addr[15:8], 1'b0, c);
        end else begin
          r.s.held_status = STATUS_UNSUPP;
          r = f_go(r, P_SP0, 1'b0, c);
        end
      end
      S_RLO: begin
        r.s.stage = S_RDONE;
        r = f_send(r, r.s.held_reg_addr[7:0], 1'b0, c);
      end
      S_RDONE: begin
        if (r.s.held_kind == KIND_REG_READ) begin
          r.s.stage = S_RA;
          r = f_go(r, P_RS1, 1'b1, c);
        end else begin
          r.s.stage = S_DW;
        end
      end
      S_RA: begin
        r.s.stage = S_DR;
        if (c.ten_bit_address) r = f_send(r, hi | 8'h01, 1'b1, c);
        else r = f_send(r, lo7 | 8'h01, 1'b1, c);
      end
      S_DW: begin
        if (r.s.bytes_left == 16'd0) begin
          r = f_go(r, P_SP0, 1'b0, c);
        end else begin
          r.s.phase = P_REQ;
          r.stop = 1'b1;
        end
      end
      S_DR: begin
        if (r.s.bytes_left == 16'd0) begin
          r = f_go(r, P_SP0, 1'b0, c);
        end else begin
          r.s.sda_d = 1'b1;
          r.s.rx_mode = 1'b1;
          r.s.bit_index = 4'd0;
          r.s.shift_byte = 8'd0;
          r = f_go(r, P_RB1, 1'b1, c);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic step_t f_step(step_t a, cfg_t c, logic first, logic scl, logic sda);
    step_t r;
    r = a;
    unique case (r.s.phase)
      P_ST1: begin
        r.s.scl_d = 1'b1;
        r = f_go(r, P_ST2, 1'b1, c);
      end
      P_ST2: begin
        if (!first) begin
          r.stop = 1'b1;
        end else if (!sda || !scl) begin
          r.s.held_status = STATUS_BUS_ERR;
          r = f_go(r, P_SP0, 1'b0, c);
        end else begin
          r.s.sda_d = 1'b0;
          r = f_go(r, P_ST3, 1'b1, c);
        end
      end
      P_ST3: begin r.s.scl_d = 1'b0; r = f_go(r, P_NEXT, 1'b0, c); end
      P_RS1: begin r.s.sda_d = 1'b1; r = f_go(r, P_RS2, 1'b1, c); end
      P_RS2: begin r.s.scl_d = 1'b1; r = f_go(r, P_RS3, 1'b1, c); end
      P_RS3: begin r.s.sda_d = 1'b0; r = f_go(r, P_RS4, 1'b1, c); end
      P_RS4: begin r.s.scl_d = 1'b0; r = f_go(r, P_NEXT, 1'b0, c); end
      P_SP0: begin r.s.scl_d = 1'b0; r = f_go(r, P_SP1, 1'b1, c); end
      P_SP1: begin r.s.sda_d = 1'b0; r = f_go(r, P_SP2, 1'b1, c); end
      P_SP2: begin r.s.scl_d = 1'b1; r = f_go(r, P_SP3, 1'b0, c); end
      P_SP3: r = f_stretch(r, c, first, scl, P_SP4);
      P_SP4: begin r.s.sda_d = 1'b1; r = f_go(r, P_SP5, 1'b1, c); end
      P_SP5: begin
        r.s.phase = P_IDLE;
        r.out_done = 1'b1;
        r.stop = 1'b1;
      end
      P_WB0: begin r.s.sda_d = r.s.shift_byte[7]; r = f_go(r, P_WB1, 1'b1, c); end
      P_WB1: begin r.s.scl_d = 1'b1; r = f_go(r, P_WB2, 1'b0, c); end
      P_WB2: r = f_stretch(r, c, first, scl, P_WB3);
      P_WB3: begin
        r.s.scl_d = 1'b0;
        r.s.shift_byte = {r.s.shift_byte[6:0], 1'b0};
        r.s.bit_index = r.s.bit_index + 4'd1;
        if (r.s.bit_index < 4'd8) begin
          r = f_go(r, P_WB0, 1'b1, c);
        end else if (r.s.rx_mode) begin
          r.s.bytes_left = r.s.bytes_left - 16'd1;
          r = f_go(r, P_NEXT, 1'b1, c);
        end else begin
          r.s.sda_d = 1'b1;
          r = f_go(r, P_RBD, 1'b1, c);
        end
      end
      P_RBD: r = f_go(r, P_RB1, 1'b1, c);
      P_RB1: begin r.s.scl_d = 1'b1; r = f_go(r, P_RB2, 1'b0, c); end
      P_RB2: r = f_stretch(r, c, first, scl, P_RB3);
      P_RB3: begin
        if (!first) begin
          r.stop = 1'b1;
        end else begin
          r.s.scl_d = 1'b0;
          if (r.s.rx_mode) begin
            r.s.shift_byte = {r.s.shift_byte[6:0], sda};
            r.s.bit_index = r.s.bit_index + 4'd1;
            if (r.s.bit_index < 4'd8) begin
              r = f_go(r, P_RB1, 1'b1, c);
            end else begin
              r.out_byte = r.s.shift_byte;
              r.out_vld = 1'b1;
              r.s.shift_byte = (r.s.bytes_left > 16'd1) ? ACK_BYTE : NACK_BYTE;
              r.s.bit_index = 4'd7;
              r = f_go(r, P_WB0, 1'b1, c);
            end
          end else if (sda) begin
            r.s.held_status = r.s.addr_flag ? STATUS_ADDR_NAK : STATUS_DATA_NAK;
            r = f_go(r, P_SP0, 1'b0, c);
          end else begin
            r = f_go(r, P_NEXT, 1'b0, c);
          end
        end
      end
      P_NEXT: r = f_seq(r, c);
      default: r.stop = 1'b1;
    endcase
    return r;
  endfunction

  assign in_stall = stepping || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    x = '0;
    x.s = core;
    unique case (in_data.mode)
      MODE_BEGIN: begin
        if (core.phase == P_IDLE) begin
          x.s.held_kind = in_data.kind;
          x.s.held_reg_addr = in_data.reg_addr;
          x.s.bytes_left = in_data.byte_count;
          x.s.held_status = STATUS_OK;
          x.s.stage = S_A1;
          x.s.stretch_count = 16'd0;
          x.s.sda_d = 1'b1;
          x = f_go(x, P_ST1, 1'b1, cfg);
        end
      end
      MODE_BYTE: begin
        if (core.phase == P_REQ) begin
          x.s.bytes_left = core.bytes_left - 16'd1;
          x = f_send(x, in_data.write_byte, 1'b0, cfg);
        end
      end
      MODE_TICK: begin
        if (core.delay_count != 16'd0) begin
          x.s.delay_count = core.delay_count - 16'd1;
          x.stop = (x.s.delay_count != 16'd0);
        end
      end
      default: ;
    endcase
    if (in_data.mode != MODE_TICK) x.stop = 1'b1;
    work_next = stepping ? work : x;
    for (int k = 0; k < StepsPerCycle; k++) begin
      if (!work_next.stop) begin
        work_next = f_step(work_next, cfg, !stepping && (k == 0), in_data.scl_level,
                           in_data.sda_level);
      end
    end
    core_next = work_next.s;
    finish = (accept || stepping) && work_next.stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      core <= '{phase: P_IDLE, stage: S_A1, bit_index: '0, shift_byte: '0,
                delay_count: '0, stretch_count: '0, bytes_left: '0, held_kind: '0,
                held_reg_addr: '0, held_status: '0, scl_d: 1'b1, sda_d: 1'b1,
                rx_mode: 1'b0, addr_flag: 1'b0};
      out_valid <= 1'b0;
      stepping <= 1'b0;
    end else begin
      if (finish) begin
        core <= core_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept && !work_next.stop) begin
        stepping <= 1'b1;
      end else if (finish) begin
        stepping <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept || stepping) begin
      work <= work_next;
    end
    if (finish) begin
      out_data.scl_drive    <= core_next.scl_d;
      out_data.sda_drive    <= core_next.sda_d;
      out_data.read_byte    <= work_next.out_byte;
      out_data.read_valid   <= work_next.out_vld;
      out_data.byte_request <= (core_next.phase == P_REQ);
      out_data.busy_res     <= (core_next.phase != P_IDLE);
      out_data.done_res     <= work_next.out_done;
      out_data.status       <= core_next.held_status;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while still busy");
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_request |-> out_data.busy_res)
    else $error("byte request outside a transaction");
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.read_valid |-> out_data.read_byte == 8'd0)
    else $error("read byte set without a received byte");
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    core.phase == P_IDLE && $past(accept) |-> core.scl_d && core.sda_d)
    else $error("line held low while idle");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import i2cm_pkg::*;

  typedef struct {
    in_t item;
    bit  follow;
  } entry_t;

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 0;
  out_t       out_data;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  i2c_master_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  entry_t pending_items[$];
  out_t   predicted_outputs[$];
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     errors = 0;
  int     items_sent = 0;
  int     bytes_read = 0;
  int     txns_done = 0;

  // Model of the bus master.
  cfg_t       cfg_model;
  phase_t     bus_phase;
  stage_t     seq_stage;
  logic [3:0] bit_cnt;
  logic [7:0] shreg;
  logic [15:0] delay_left, stretch_cnt, bytes_rem, txn_reg;
  logic [1:0] txn_kind;
  logic [2:0] txn_status;
  logic       drv_scl, drv_sda, rx_flag, addr_flag_q;
  logic [7:0] ev_byte;
  logic       ev_valid, ev_done;

  function automatic void model_reset();
    cfg_model = '{device_address: 10'd0, ten_bit_address: 1'b0, reg_addr_width: 2'd0,
                  half_period: 16'd5, stretch_enable: 1'b0, stretch_timeout: 16'd1000};
    bus_phase = P_IDLE; seq_stage = S_A1; bit_cnt = 0; shreg = 0; delay_left = 0;
    stretch_cnt = 0; bytes_rem = 0; txn_reg = 0; txn_kind = 0; txn_status = 0;
    drv_scl = 1; drv_sda = 1; rx_flag = 0; addr_flag_q = 0;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [15:0] val);
    case (idx)
      CFG_DEV_ADDR: cfg_model.device_address = val[9:0];
      CFG_TEN_BIT:  cfg_model.ten_bit_address = val[0];
      CFG_RAW:      cfg_model.reg_addr_width = val[1:0];
      CFG_HALF:     cfg_model.half_period = val;
      CFG_STR_EN:   cfg_model.stretch_enable = val[0];
      CFG_STR_TO:   cfg_model.stretch_timeout = val;
      default: ;
    endcase
  endfunction

  function automatic bit go_to(phase_t nxt, bit wait_step);
    bus_phase = nxt;
    if (wait_step && cfg_model.half_period != 0) begin
      delay_left = cfg_model.half_period;
      return 1;
    end
    return 0;
  endfunction

  function automatic bit start_byte(logic [7:0] b, bit is_addr);
    shreg = b;
    bit_cnt = 0;
    rx_flag = 0;
    addr_flag_q = is_addr;
    return go_to(P_WB0, 1);
  endfunction

  function automatic bit stretch_hold(logic scl, bit first);
    if (!cfg_model.stretch_enable) return 0;
    if (!first) return 1;
    if (scl || stretch_cnt >= cfg_model.stretch_timeout) begin
      stretch_cnt = 0;
      return 0;
    end
    stretch_cnt++;
    return 1;
  endfunction

  function automatic bit next_stage();
    logic [7:0] hi;
    logic       dir;
    hi = {5'b11110, cfg_model.device_address[9:8], 1'b0};
    for (int guard = 0; guard < 16; guard++) begin
      case (seq_stage)
        S_A1: begin
          dir = (txn_kind == KIND_READ && !cfg_model.ten_bit_address);
          seq_stage = cfg_model.ten_bit_address ? S_A2 : S_AFTER;
          if (cfg_model.ten_bit_address) return start_byte(hi | {7'd0, dir}, 1);
          return start_byte({cfg_model.device_address[6:0], dir}, 1);
        end
        S_A2: begin
          seq_stage = S_AFTER;
          return start_byte(cfg_model.device_address[7:0], 1);
        end
        S_AFTER: begin
          if (txn_kind == KIND_WRITE) begin
            seq_stage = S_DW;
          end else if (txn_kind == KIND_READ) begin
            if (cfg_model.ten_bit_address) begin
              seq_stage = S_RA;
              return go_to(P_RS1, 1);
            end
            seq_stage = S_DR;
          end else if (cfg_model.reg_addr_width == RAW_8) begin
            seq_stage = S_RDONE;
            return start_byte(txn_reg[7:0], 0);
          end else if (cfg_model.reg_addr_width == RAW_16) begin
            seq_stage = S_RLO;
            return start_byte(txn_reg[15:8], 0);
          end else begin
            txn_status = STATUS_UNSUPP;
            return go_to(P_SP0, 0);
          end
        end
        S_RLO: begin
          seq_stage = S_RDONE;
          return start_byte(txn_reg[7:0], 0);
        end
        S_RDONE: begin
          if (txn_kind == KIND_REG_READ) begin
            seq_stage = S_RA;
            return go_to(P_RS1, 1);
          end
          seq_stage = S_DW;
        end
        S_RA: begin
          seq_stage = S_DR;
          if (cfg_model.ten_bit_address) return start_byte(hi | 8'h01, 1);
          return start_byte({cfg_model.device_address[6:0], 1'b1}, 1);
        end
        S_DW: begin
          if (bytes_rem == 0) return go_to(P_SP0, 0);
          bus_phase = P_REQ;
          return 1;
        end
        default: begin
          if (bytes_rem == 0) return go_to(P_SP0, 0);
          drv_sda = 1;
          rx_flag = 1;
          bit_cnt = 0;
          shreg = 0;
          return go_to(P_RB1, 1);
        end
      endcase
    end
    return 1;
  endfunction

  function automatic bit bus_action(logic scl, logic sda, bit first);
    case (bus_phase)
      P_ST1: begin drv_scl = 1; return go_to(P_ST2, 1); end
      P_ST2: begin
        if (!first) return 1;
        if (!sda || !scl) begin
          txn_status = STATUS_BUS_ERR;
          return go_to(P_SP0, 0);
        end
        drv_sda = 0;
        return go_to(P_ST3, 1);
      end
      P_ST3: begin drv_scl = 0; return go_to(P_NEXT, 0); end
      P_RS1: begin drv_sda = 1; return go_to(P_RS2, 1); end
      P_RS2: begin drv_scl = 1; return go_to(P_RS3, 1); end
      P_RS3: begin drv_sda = 0; return go_to(P_RS4, 1); end
      P_RS4: begin drv_scl = 0; return go_to(P_NEXT, 0); end
      P_SP0: begin drv_scl = 0; return go_to(P_SP1, 1); end
      P_SP1: begin drv_sda = 0; return go_to(P_SP2, 1); end
      P_SP2: begin drv_scl = 1; return go_to(P_SP3, 0); end
      P_SP3: begin
        if (stretch_hold(scl, first)) return 1;
        return go_to(P_SP4, 1);
      end
      P_SP4: begin drv_sda = 1; return go_to(P_SP5, 1); end
      P_SP5: begin bus_phase = P_IDLE; ev_done = 1; return 1; end
      P_WB0: begin drv_sda = shreg[7]; return go_to(P_WB1, 1); end
      P_WB1: begin drv_scl = 1; return go_to(P_WB2, 0); end
      P_WB2: begin
        if (stretch_hold(scl, first)) return 1;
        return go_to(P_WB3, 1);
      end
      P_WB3: begin
        drv_scl = 0;
        shreg = shreg << 1;
        bit_cnt++;
        if (bit_cnt < 8) return go_to(P_WB0, 1);
        if (rx_flag) begin
          bytes_rem--;
          return go_to(P_NEXT, 1);
        end
        drv_sda = 1;
        return go_to(P_RBD, 1);
      end
      P_RBD: return go_to(P_RB1, 1);
      P_RB1: begin drv_scl = 1; return go_to(P_RB2, 0); end
      P_RB2: begin
        if (stretch_hold(scl, first)) return 1;
        return go_to(P_RB3, 1);
      end
      P_RB3: begin
        if (!first) return 1;
        drv_scl = 0;
        if (rx_flag) begin
          shreg = {shreg[6:0], sda};
          bit_cnt++;
          if (bit_cnt < 8) return go_to(P_RB1, 1);
          ev_byte = shreg;
          ev_valid = 1;
          shreg = (bytes_rem > 1) ? ACK_BYTE : NACK_BYTE;
          bit_cnt = 7;
          return go_to(P_WB0, 1);
        end
        if (sda) begin
          txn_status = addr_flag_q ? STATUS_ADDR_NAK : STATUS_DATA_NAK;
          return go_to(P_SP0, 0);
        end
        return go_to(P_NEXT, 0);
      end
      P_NEXT: return next_stage();
      default: return 1;
    endcase
  endfunction

  function automatic out_t bus_predict_step(in_t it);
    out_t r;
    bit   first;
    bit   pending;
    ev_byte = 0;
    ev_valid = 0;
    ev_done = 0;
    if (it.mode == MODE_BEGIN) begin
      if (bus_phase == P_IDLE) begin
        txn_kind = it.kind;
        txn_reg = it.reg_addr;
        bytes_rem = it.byte_count;
        txn_status = STATUS_OK;
        seq_stage = S_A1;
        stretch_cnt = 0;
        drv_sda = 1;
        void'(go_to(P_ST1, 1));
      end
    end else if (it.mode == MODE_BYTE) begin
      if (bus_phase == P_REQ) begin
        bytes_rem--;
        void'(start_byte(it.write_byte, 0));
      end
    end else if (it.mode == MODE_TICK) begin
      pending = 0;
      if (delay_left != 0) begin
        delay_left--;
        if (delay_left != 0) pending = 1;
      end
      if (!pending) begin
        first = 1;
        while (!bus_action(it.scl_level, it.sda_level, first)) first = 0;
      end
    end
    r.scl_drive = drv_scl;
    r.sda_drive = drv_sda;
    r.read_byte = ev_byte;
    r.read_valid = ev_valid;
    r.byte_request = (bus_phase == P_REQ);
    r.busy_res = (bus_phase != P_IDLE);
    r.done_res = ev_done;
    r.status = txn_status;
    return r;
  endfunction

  // Turns a bus-following entry into the item a device on the bus would cause now.
  function automatic in_t shape_item(entry_t e);
    in_t it;
    bit  rx_window;
    it = e.item;
    if (!e.follow) begin
      if (it.mode == MODE_BEGIN && bus_phase == P_IDLE) it.byte_count &= 16'd3;
      return it;
    end
    if (bus_phase == P_REQ && $urandom_range(0, 2) == 0) begin
      it.mode = MODE_BYTE;
    end else if (bus_phase == P_IDLE && $urandom_range(0, 3) == 0) begin
      it.mode = MODE_BEGIN;
    end else begin
      it.mode = MODE_TICK;
      rx_window = (bus_phase inside {P_RBD, P_RB1, P_RB2, P_RB3});
      it.scl_level = drv_scl & ($urandom_range(0, 7) != 0);
      if (rx_window) it.sda_level = drv_sda & ($urandom_range(0, 4) == 0);
      else it.sda_level = drv_sda & ($urandom_range(0, 31) != 0);
      if (bus_phase == P_ST2) it.scl_level = drv_scl & ($urandom_range(0, 15) != 0);
    end
    return it;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    entry_t e;
    in_t    nxt;
    bit     take;
    if (rst) begin
      in_valid <= 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        predicted_outputs.push_back(bus_predict_step(in_data));
        items_sent++;
      end
      if (!in_valid || take) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          e = pending_items.pop_front();
          nxt = shape_item(e);
          in_data <= nxt;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    bit   bad;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer on output: %p", out_data);
        end else begin
          want = predicted_outputs.pop_front();
          bad = 0;
          if (out_data.scl_drive !== want.scl_drive) bad = 1;
          if (out_data.sda_drive !== want.sda_drive) bad = 1;
          if (out_data.read_byte !== want.read_byte) bad = 1;
          if (out_data.read_valid !== want.read_valid) bad = 1;
          if (out_data.byte_request !== want.byte_request) bad = 1;
          if (out_data.busy_res !== want.busy_res) bad = 1;
          if (out_data.done_res !== want.done_res) bad = 1;
          if (out_data.status !== want.status) bad = 1;
          if (bad) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, out_data);
          end else begin
            if (want.read_valid) bytes_read++;
            if (want.done_res) txns_done++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, val);
    cfg_valid <= 0;
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || predicted_outputs.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_random(int n, bit begins_ok);
    entry_t e;
    for (int i = 0; i < n; i++) begin
      e.item.mode = MODE_TICK;
      e.item.kind = 2'($urandom_range(0, 3));
      e.item.reg_addr = 16'($urandom);
      e.item.byte_count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(4, 6))
                                                      : 16'($urandom_range(0, 3));
      e.item.write_byte = 8'($urandom);
      e.item.scl_level = 1;
      e.item.sda_level = 1;
      e.follow = 1;
      if ($urandom_range(0, 99) < 15) begin
        e.item.mode = 2'($urandom_range(0, 3));
        e.item.kind = 2'($urandom_range(0, 3));
        e.item.write_byte = 8'($urandom);
        e.item.scl_level = 1'($urandom_range(0, 1));
        e.item.sda_level = 1'($urandom_range(0, 1));
        e.item.byte_count = 16'($urandom);
        e.item.reg_addr = 16'($urandom);
        e.follow = 0;
      end
      if (!begins_ok) begin
        e.follow = 0;
        e.item.mode = MODE_TICK;
      end
      pending_items.push_back(e);
    end
  endtask

  task automatic add_item(logic [1:0] m, logic [1:0] k, logic [15:0] ra, logic [15:0] cnt,
                          logic [7:0] wb, bit follow);
    entry_t e;
    e.item = '{mode: m, kind: k, reg_addr: ra, byte_count: cnt, write_byte: wb,
               scl_level: 1'b1, sda_level: 1'b1};
    e.follow = follow;
    pending_items.push_back(e);
  endtask

  initial begin
    model_reset();
    repeat (8) @(posedge clk);
    rst <= 0;

    // Directed: each kind, ignored items, extreme field values.
    add_item(MODE_BYTE, KIND_WRITE, 16'h0000, 16'h0000, 8'hFF, 0);
    add_item(2'd3, KIND_REG_READ, 16'hFFFF, 16'hFFFF, 8'hFF, 0);
    add_item(MODE_BEGIN, KIND_WRITE, 16'h0000, 16'd0, 8'h00, 0);
    add_item(MODE_BEGIN, KIND_READ, 16'hFFFF, 16'hFFFF, 8'hFF, 0);
    for (int i = 0; i < 6; i++) add_item(MODE_TICK, KIND_WRITE, 0, 0, 8'h00, 1);
    add_item(MODE_TICK, KIND_WRITE, 0, 0, 8'h00, 0);
    add_item(MODE_TICK, KIND_WRITE, 0, 0, 8'h00, 0);
    for (int k = 0; k < 4; k++) begin
      add_item(MODE_TICK, k[1:0], 16'hFFFF, 16'd2, 8'hA5, 1);
      add_item(MODE_TICK, k[1:0], 16'h00FF, 16'd1, 8'hFF, 1);
    end
    add_random(250, 1);
    settle();

    write_reg(CFG_DEV_ADDR, 16'h03FF);
    write_reg(CFG_RAW, 16'd1);
    write_reg(CFG_HALF, 16'd0);
    write_reg(CFG_STR_EN, 16'd1);
    write_reg(CFG_STR_TO, 16'd0);
    send_idle_pct = 86;
    add_random(300, 1);
    settle();

    write_reg(CFG_DEV_ADDR, 16'h02A5);
    write_reg(CFG_TEN_BIT, 16'd1);
    write_reg(CFG_RAW, 16'd2);
    write_reg(CFG_HALF, 16'd1);
    write_reg(CFG_STR_TO, 16'hFFFF);
    send_idle_pct = 0;
    stall_pct = 86;
    add_random(300, 1);
    settle();

    write_reg(CFG_DEV_ADDR, 16'($urandom_range(0, 1023)));
    write_reg(CFG_RAW, 16'd0);
    write_reg(CFG_HALF, 16'd2);
    write_reg(CFG_STR_TO, 16'd3);
    send_idle_pct = 38;
    stall_pct = 38;
    add_random(300, 1);
    settle();

    // The longest delay step, with the bus left idle so no transaction hangs on it.
    write_reg(CFG_HALF, 16'hFFFF);
    send_idle_pct = 0;
    stall_pct = 0;
    add_random(10, 0);
    settle();

    write_reg(CFG_DEV_ADDR, 16'h0000);
    write_reg(CFG_TEN_BIT, 16'd0);
    write_reg(CFG_RAW, 16'd1);
    write_reg(CFG_HALF, 16'd1);
    write_reg(CFG_STR_EN, 16'd0);
    add_random(300, 1);
    settle();
    repeat (10) @(posedge clk);

    errors += predicted_outputs.size();
    $display("Sent %0d items over six register settings and four handshake patterns.",
             items_sent);
    $display("Saw %0d received bytes and %0d completed transactions.", bytes_read, txns_done);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in total.", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d items pending.", pending_items.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
design/i2cm_pkg.sv
design/i2cm_cfg.sv
design/i2c_master_controller.sv
verif/testbench.sv
